@@ hdl/smpd_pkg.sv @@
package smpd_pkg;

	localparam int unsigned TAIL_OFFSET = 38;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL_MARKER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CRC_SIZE     = 2'd2;

	localparam logic [15:0] START_MARKER_RST = 16'hF0FE;
	localparam logic [15:0] TAIL_MARKER_RST  = 16'h0000;
	localparam logic [5:0]  CRC_SIZE_RST     = 6'd4;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_DRAIN,
		ST_PASS
	} state_t;

	// shift command for the header window chain
	typedef struct packed {
		logic       en;
		logic [7:0] data;
	} shift_t;

endpackage

@@ hdl/smpd_cell.sv @@
module smpd_cell (
	input  logic       clk,
	input  logic       shift_en,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

@@ hdl/smpd_window.sv @@
module smpd_window #(
	parameter int unsigned HEADER_BYTES = 40
) (
	input  logic           clk,
	input  smpd_pkg::shift_t shift,
	output logic [7:0]     cells [HEADER_BYTES]
);

	// new bytes enter at the tail and move toward cell 0 (oldest byte)
	genvar i;
	generate
		for (i = 0; i < HEADER_BYTES; i++) begin : g_cell
			logic [7:0] d;
			if (i == HEADER_BYTES - 1) begin : g_tail
				assign d = shift.data;
			end else begin : g_body
				assign d = cells[i+1];
			end
			smpd_cell u_cell (
				.clk      (clk),
				.shift_en (shift.en),
				.d        (d),
				.q        (cells[i])
			);
		end
	endgenerate

endmodule

@@ hdl/sync_marker_packet_deframer_core.sv @@
// Hunting: one input word per cycle; header check runs on the full window in the same cycle.
// On a match the input is held off while the state leaves the hunt and the header drains
// from cell 0 of the window chain, one word per cycle while the output is not stalled;
// payload words follow. A payload word is on the output the cycle after it is taken; the
// first header word goes from the full window through the drain state and the output register.
// Reset (arst_n low, asynchronous): hunt state, empty window, registers at reset values.
module sync_marker_packet_deframer_core #(
	parameter int unsigned HEADER_BYTES = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] pkt_byte, [23:8] pkt_length
	output logic        m_axis_tuser,   // [0] first_of_packet
	output logic        m_axis_tlast,   // last_of_packet
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [smpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned FILL_W = $clog2(HEADER_BYTES + 1);
	localparam int unsigned CNT_W  = $clog2(HEADER_BYTES);

	smpd_pkg::state_t state_q, state_nxt;
	smpd_pkg::shift_t shift;

	logic [7:0]        cells [HEADER_BYTES];
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  drain_cnt_q;
	logic [15:0]       rem_q;
	logic [15:0]       cur_len_q;
	logic [15:0]       start_q;
	logic [15:0]       tail_q;
	logic [5:0]        crc_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [15:0] out_len_q;
	logic        out_first_q;
	logic        out_last_q;

	logic        win_full, hdr_ok, out_free, s_acc, ld, drain_end;
	logic [15:0] len_w;
	logic [7:0]  nxt_byte;
	logic        nxt_first, nxt_last;

	smpd_window #(.HEADER_BYTES(HEADER_BYTES)) u_window (
		.clk   (clk),
		.shift (shift),
		.cells (cells)
	);

	assign win_full = (fill_q == FILL_W'(HEADER_BYTES));
	assign len_w    = {cells[3], cells[2]};
	assign hdr_ok   = ({cells[1], cells[0]} == start_q)
		&& ({cells[smpd_pkg::TAIL_OFFSET+1], cells[smpd_pkg::TAIL_OFFSET]} == tail_q)
		&& ({1'b0, len_w} >= (17'(HEADER_BYTES) + 17'(crc_q)));
	assign out_free  = !out_valid_q || m_axis_tready;
	assign s_acc     = s_axis_tvalid && s_axis_tready;
	assign drain_end = (drain_cnt_q == CNT_W'(HEADER_BYTES - 1));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			smpd_pkg::ST_HUNT: begin
				if (win_full && hdr_ok) begin
					state_nxt = smpd_pkg::ST_DRAIN;
				end
			end
			smpd_pkg::ST_DRAIN: begin
				if (out_free && drain_end) begin
					state_nxt = (rem_q == 16'd0) ? smpd_pkg::ST_HUNT : smpd_pkg::ST_PASS;
				end
			end
			smpd_pkg::ST_PASS: begin
				if (s_acc && rem_q == 16'd1) begin
					state_nxt = smpd_pkg::ST_HUNT;
				end
			end
			default: state_nxt = smpd_pkg::ST_HUNT;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		ld            = 1'b0;
		shift.en      = 1'b0;
		shift.data    = s_axis_tdata;
		nxt_byte      = s_axis_tdata;
		nxt_first     = 1'b0;
		nxt_last      = 1'b0;
		case (state_q)
			smpd_pkg::ST_HUNT: begin
				// a rejected full window drops its oldest byte with the next shift
				s_axis_tready = !win_full || !hdr_ok;
				shift.en      = s_axis_tvalid && (!win_full || !hdr_ok);
			end
			smpd_pkg::ST_DRAIN: begin
				ld        = out_free;
				shift.en  = out_free;
				nxt_byte  = cells[0];
				nxt_first = (drain_cnt_q == '0);
				nxt_last  = drain_end && (cur_len_q == 16'(HEADER_BYTES));
			end
			smpd_pkg::ST_PASS: begin
				s_axis_tready = out_free;
				ld            = s_axis_tvalid && out_free;
				nxt_last      = (rem_q == 16'd1);
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= smpd_pkg::ST_HUNT;
			fill_q      <= '0;
			drain_cnt_q <= '0;
			rem_q       <= '0;
			cur_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				smpd_pkg::ST_HUNT: begin
					if (win_full && hdr_ok) begin
						fill_q      <= '0;
						drain_cnt_q <= '0;
						cur_len_q   <= len_w;
						rem_q       <= len_w - 16'(HEADER_BYTES);
					end else if (s_acc) begin
						if (!win_full) begin
							fill_q <= fill_q + FILL_W'(1);
						end
					end else if (win_full) begin
						fill_q <= FILL_W'(HEADER_BYTES - 1);
					end
				end
				smpd_pkg::ST_DRAIN: begin
					if (ld) begin
						drain_cnt_q <= drain_cnt_q + CNT_W'(1);
					end
				end
				smpd_pkg::ST_PASS: begin
					if (s_acc) begin
						rem_q <= rem_q - 16'd1;
					end
				end
				default: begin
					fill_q <= '0;
				end
			endcase
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_byte_q  <= nxt_byte;
			out_first_q <= nxt_first;
			out_last_q  <= nxt_last;
			out_len_q   <= cur_len_q;
		end
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= smpd_pkg::START_MARKER_RST;
			tail_q  <= smpd_pkg::TAIL_MARKER_RST;
			crc_q   <= smpd_pkg::CRC_SIZE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				smpd_pkg::CFG_START_MARKER: start_q <= cfg_data;
				smpd_pkg::CFG_TAIL_MARKER:  tail_q  <= cfg_data;
				smpd_pkg::CFG_CRC_SIZE:     crc_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_len_q, out_byte_q};
	assign m_axis_tuser  = out_first_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ hdl/smpd_checker.sv @@
module smpd_checker #(
	parameter int unsigned HEADER_BYTES = 40
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// a packet never announces a length shorter than its header
	a_len_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[23:8] >= 16'(HEADER_BYTES))
		else $error("packet length below header size");

	// the first header word is never the last word of a packet
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
		else $error("first word flagged as last");

	// header burst continues without a gap after its first word is taken
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser |=> m_axis_tvalid && !m_axis_tuser)
		else $error("header burst broken");

endmodule

bind sync_marker_packet_deframer_core smpd_checker #(.HEADER_BYTES(HEADER_BYTES)) u_smpd_chk (.*);

@@ tb/sync_marker_packet_deframer_core_tb.sv @@
`timescale 1ns / 100ps

module sync_marker_packet_deframer_core_tb;

	localparam int unsigned HDR = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD = 400;

	// Mirrors the deframer: header window, packet countdown, expected output words
	class deframe_scoreboard;
		localparam int unsigned HB = HDR;

		typedef struct packed {
			logic [7:0]  data;
			logic        first;
			logic        last;
			logic [15:0] length;
		} pkt_word_t;

		logic [7:0]  window [HB];
		int unsigned fill;
		logic [15:0] remaining;
		logic [15:0] cur_len;
		logic [15:0] start_marker;
		logic [15:0] tail_marker;
		logic [5:0]  crc_size;
		pkt_word_t   pending [$];
		int          errors;
		int          checked;
		int          packets;

		function new();
			fill = 0;
			remaining = '0;
			cur_len = '0;
			start_marker = smpd_pkg::START_MARKER_RST;
			tail_marker = smpd_pkg::TAIL_MARKER_RST;
			crc_size = smpd_pkg::CRC_SIZE_RST;
			errors = 0;
			checked = 0;
			packets = 0;
		endfunction

		function void set_reg(logic [smpd_pkg::CFG_IDX_W-1:0] idx, logic [15:0] d);
			case (idx)
				smpd_pkg::CFG_START_MARKER: start_marker = d;
				smpd_pkg::CFG_TAIL_MARKER: tail_marker = d;
				smpd_pkg::CFG_CRC_SIZE: crc_size = d[5:0];
				default: ;
			endcase
		endfunction

		function void note_rx_byte(logic [7:0] b);
			logic [15:0] len;
			pkt_word_t w;
			if (remaining != 0) begin
				w.data = b;
				w.first = 1'b0;
				w.last = (remaining == 16'd1);
				w.length = cur_len;
				pending.push_back(w);
				remaining--;
				return;
			end
			if (fill < HB) begin
				window[fill] = b;
				fill++;
			end
			if (fill < HB)
				return;
			len = {window[3], window[2]};
			if ({window[1], window[0]} == start_marker &&
					{window[smpd_pkg::TAIL_OFFSET+1], window[smpd_pkg::TAIL_OFFSET]}
						== tail_marker &&
					int'(len) >= int'(HB) + int'(crc_size)) begin
				cur_len = len;
				packets++;
				for (int i = 0; i < HB; i++) begin
					w.data = window[i];
					w.first = (i == 0);
					w.last = (i == HB - 1) && (int'(len) == int'(HB));
					w.length = len;
					pending.push_back(w);
				end
				remaining = len - 16'(HB);
				fill = 0;
			end else begin
				// slide by one, oldest byte dropped
				for (int i = 0; i < HB - 1; i++)
					window[i] = window[i+1];
				fill = HB - 1;
			end
		endfunction

		task report_mismatch(string what, int got, int want);
			errors++;
			if (errors <= 30)
				$display("ERROR %0t: %0s got %0h expected %0h", $time, what, got, want);
		endtask

		task check_pkt_word(logic [23:0] data, logic user, logic last);
			pkt_word_t w;
			checked++;
			if (pending.size() == 0) begin
				report_mismatch("unexpected word", data, 0);
				return;
			end
			w = pending.pop_front();
			if (data[7:0] !== w.data)
				report_mismatch("pkt_byte", data[7:0], w.data);
			if (data[23:8] !== w.length)
				report_mismatch("pkt_length", data[23:8], w.length);
			if (user !== w.first)
				report_mismatch("first_of_packet", user, w.first);
			if (last !== w.last)
				report_mismatch("last_of_packet", last, w.last);
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [23:0]          m_axis_tdata;   // [7:0] pkt_byte, [23:8] pkt_length
	logic                 m_axis_tuser;   // [0] first_of_packet
	logic                 m_axis_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [smpd_pkg::CFG_IDX_W-1:0] cfg_index = smpd_pkg::CFG_START_MARKER;
	logic [15:0]          cfg_data = '0;

	deframe_scoreboard sb = new();

	bit          send_idle_on = 1'b1;
	bit          recv_idle_on = 1'b1;
	bit          long_stall_req = 1'b0;
	int          rx_words = 0;
	int          n_settings = 1;
	int          quiet_cycles = 0;
	logic [15:0] cur_start = smpd_pkg::START_MARKER_RST;
	logic [15:0] cur_tail = smpd_pkg::TAIL_MARKER_RST;
	logic [5:0]  cur_crc = smpd_pkg::CRC_SIZE_RST;

	sync_marker_packet_deframer_core #(
		.HEADER_BYTES(HDR)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("sync_marker_packet_deframer_core_tb NOT OK");
			$finish;
		end
	end

	// receiver: random stalls per word, one long hold-off on request
	initial begin
		int stall;
		forever begin
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			stall = recv_idle_on ? $urandom_range(0, 10) : 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			sb.check_pkt_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		end
	end

	// valid is left high; the next call lowers it only for an idle gap, settle() lowers it
	task automatic send_rx_byte(input logic [7:0] b);
		int gap;
		gap = send_idle_on ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_rx_byte(b);
		rx_words++;
	endtask

	// sends the first nbytes of a frame; header fields as given, rest random or marker bytes
	task automatic send_frame(input logic [15:0] sm, input logic [15:0] tm, input int len,
			input int nbytes, input bit marker_payload);
		logic [7:0]  b;
		logic [15:0] lf;
		lf = len[15:0];
		for (int i = 0; i < nbytes; i++) begin
			if (i == 0)
				b = sm[7:0];
			else if (i == 1)
				b = sm[15:8];
			else if (i == 2)
				b = lf[7:0];
			else if (i == 3)
				b = lf[15:8];
			else if (i == int'(smpd_pkg::TAIL_OFFSET))
				b = tm[7:0];
			else if (i == int'(smpd_pkg::TAIL_OFFSET) + 1)
				b = tm[15:8];
			else if (i >= int'(HDR) && marker_payload)
				b = i[0] ? sm[15:8] : sm[7:0];
			else
				b = 8'($urandom);
			send_rx_byte(b);
		end
	endtask

	// drain everything; a header burst may still be in flight
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (HDR + 8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [smpd_pkg::CFG_IDX_W-1:0] idx,
			input logic [15:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, d);
	endtask

	task automatic set_config(input logic [15:0] sm, input logic [15:0] tm, input logic [5:0] crc);
		settle();
		write_reg(smpd_pkg::CFG_START_MARKER, sm);
		write_reg(smpd_pkg::CFG_TAIL_MARKER, tm);
		write_reg(smpd_pkg::CFG_CRC_SIZE, {10'd0, crc});
		cfg_valid <= 1'b0;
		cur_start = sm;
		cur_tail = tm;
		cur_crc = crc;
		n_settings++;
	endtask

	// mostly good frames, some corrupted or cut short, some line noise
	task automatic random_traffic(input int n);
		int target;
		int r;
		int minlen;
		int len;
		target = rx_words + n;
		minlen = int'(HDR) + int'(cur_crc);
		while (rx_words < target) begin
			r = $urandom_range(0, 99);
			len = minlen + $urandom_range(0, (r < 5) ? 120 : 24);
			if (r < 65)
				send_frame(cur_start, cur_tail, len, len, r < 10);
			else if (r < 73)
				send_frame(cur_start ^ (16'd1 << $urandom_range(0, 15)), cur_tail, len, len, 1'b0);
			else if (r < 80)
				send_frame(cur_start, cur_tail ^ (16'd1 << $urandom_range(0, 15)), len, len, 1'b0);
			else if (r < 86)
				send_frame(cur_start, cur_tail, $urandom_range(0, minlen - 1), HDR, 1'b0);
			else if (r < 93)
				send_frame(cur_start, cur_tail, len, $urandom_range(4, HDR - 1), 1'b0);
			else
				repeat ($urandom_range(1, 12)) send_rx_byte(8'($urandom));
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: minimum length with marker-like payload
		send_frame(smpd_pkg::START_MARKER_RST, smpd_pkg::TAIL_MARKER_RST, 44, 44, 1'b1);

		// no CRC: header-only packet carries tlast on its final header word
		set_config(16'hFFFF, 16'hFFFF, 6'd0);
		send_frame(16'hFFFF, 16'hFFFF, 40, 40, 1'b0);

		set_config(16'h0000, 16'h0000, 6'd32);
		send_frame(16'h0000, 16'h0000, 72, 72, 1'b0);

		set_config(16'($urandom), 16'($urandom), 6'($urandom_range(0, 32)));
		random_traffic(80);

		// largest length field, back-to-back words while the receiver holds off
		set_config(smpd_pkg::START_MARKER_RST, smpd_pkg::TAIL_MARKER_RST,
			smpd_pkg::CRC_SIZE_RST);
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		long_stall_req = 1'b1;
		send_frame(smpd_pkg::START_MARKER_RST, smpd_pkg::TAIL_MARKER_RST, 65535, HDR + 16,
			1'b0);
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;

		settle();
		if (sb.pending.size() != 0)
			sb.report_mismatch("words never seen", sb.pending.size(), 0);
		$display("Covered %0d rx words, %0d packets framed, %0d output words checked",
			rx_words, sb.packets, sb.checked);
		$display("over %0d register settings: crc 0 and 32, markers 0000/FFFF, length 65535",
			n_settings);
		if (sb.errors == 0)
			$display("sync_marker_packet_deframer_core_tb OK");
		else
			$display("sync_marker_packet_deframer_core_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
hdl/smpd_pkg.sv
hdl/smpd_cell.sv
hdl/smpd_window.sv
hdl/sync_marker_packet_deframer_core.sv
hdl/smpd_checker.sv
tb/sync_marker_packet_deframer_core_tb.sv
